[hw/rtl/sts_pkg.sv]
// shared types, constants and character classes for the token splitter
package sts_pkg;

  localparam int OFFSET_WIDTH = 24;
  localparam int LINE_WIDTH   = 20;
  localparam int COLUMN_WIDTH = 16;
  localparam int KIND_WIDTH   = 4;
  localparam int BYTE_WIDTH   = 8;
  localparam int MAX_TOKENS   = 3;
  localparam int SLOT_WIDTH   = $clog2(MAX_TOKENS + 1);
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [KIND_WIDTH-1:0] K_EOF    = 4'd0;
  localparam logic [KIND_WIDTH-1:0] K_IDENT  = 4'd1;
  localparam logic [KIND_WIDTH-1:0] K_STRING = 4'd2;
  localparam logic [KIND_WIDTH-1:0] K_CHAR   = 4'd3;
  localparam logic [KIND_WIDTH-1:0] K_LINE   = 4'd4;
  localparam logic [KIND_WIDTH-1:0] K_BLOCK  = 4'd5;
  localparam logic [KIND_WIDTH-1:0] K_OPEN   = 4'd6;
  localparam logic [KIND_WIDTH-1:0] K_CLOSE  = 4'd7;
  localparam logic [KIND_WIDTH-1:0] K_OTHER  = 4'd8;

  localparam logic IN_BYTE = 1'b0;
  localparam logic IN_END  = 1'b1;

  localparam logic [BYTE_WIDTH-1:0] CH_NL     = 8'h0A;
  localparam logic [BYTE_WIDTH-1:0] CH_DQUOTE = 8'h22;
  localparam logic [BYTE_WIDTH-1:0] CH_SQUOTE = 8'h27;
  localparam logic [BYTE_WIDTH-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_WIDTH-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_WIDTH-1:0] CH_D0     = 8'h30;
  localparam logic [BYTE_WIDTH-1:0] CH_D9     = 8'h39;
  localparam logic [BYTE_WIDTH-1:0] CH_UA     = 8'h41;
  localparam logic [BYTE_WIDTH-1:0] CH_UZ     = 8'h5A;
  localparam logic [BYTE_WIDTH-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_WIDTH-1:0] CH_USCORE = 8'h5F;
  localparam logic [BYTE_WIDTH-1:0] CH_LA     = 8'h61;
  localparam logic [BYTE_WIDTH-1:0] CH_LZ     = 8'h7A;
  localparam logic [BYTE_WIDTH-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_WIDTH-1:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic [KIND_WIDTH-1:0]   kind;
    logic [OFFSET_WIDTH-1:0] start_offset;
    logic [OFFSET_WIDTH-1:0] token_length;
    logic [LINE_WIDTH-1:0]   start_line;
    logic [COLUMN_WIDTH-1:0] start_column;
  } tok_t;

  typedef struct packed {
    tok_t [MAX_TOKENS-1:0]   tok;
    logic [SLOT_WIDTH-1:0]   count;
  } rec_t;

  function automatic logic [OFFSET_WIDTH-1:0] sat_off(input logic [OFFSET_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [LINE_WIDTH-1:0] sat_line(input logic [LINE_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [COLUMN_WIDTH-1:0] sat_col(input logic [COLUMN_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic is_digit(input logic [BYTE_WIDTH-1:0] c);
    return (c >= CH_D0) && (c <= CH_D9);
  endfunction

  function automatic logic is_alpha(input logic [BYTE_WIDTH-1:0] c);
    return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
  endfunction

  function automatic logic is_ident_start(input logic [BYTE_WIDTH-1:0] c);
    return is_alpha(c) || (c == CH_USCORE);
  endfunction

  function automatic logic is_ident_char(input logic [BYTE_WIDTH-1:0] c);
    return is_ident_start(c) || is_digit(c);
  endfunction

  function automatic logic starts_token(input logic [BYTE_WIDTH-1:0] c, input logic dig,
                                        input logic nv, input logic [BYTE_WIDTH-1:0] n);
    return is_ident_start(c) || (c == CH_DQUOTE) || (c == CH_LBRACE) || (c == CH_RBRACE) ||
           ((c == CH_SQUOTE) && !dig) ||
           ((c == CH_SLASH) && nv && ((n == CH_SLASH) || (n == CH_STAR)));
  endfunction

endpackage

[hw/rtl/sts_ifs.sv]
// request channel interfaces for source bytes and tokens
interface sts_in_if import sts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [BYTE_WIDTH-1:0] source_byte;

  modport source (output valid, kind, source_byte, input ready);
  modport sink (input valid, kind, source_byte, output ready);
endinterface

interface sts_out_if import sts_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KIND_WIDTH-1:0]   token_kind;
  logic [OFFSET_WIDTH-1:0] start_offset;
  logic [OFFSET_WIDTH-1:0] token_length;
  logic [LINE_WIDTH-1:0]   start_line;
  logic [COLUMN_WIDTH-1:0] start_column;
  logic                    last_in_run;

  modport source (output valid, token_kind, start_offset, token_length, start_line,
                  start_column, last_in_run, input ready);
  modport sink (input valid, token_kind, start_offset, token_length, start_line,
                start_column, last_in_run, output ready);
endinterface

[hw/rtl/sts_front.sv]
// front end: lookahead byte, scanner state machine, per-request token record
module sts_front import sts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sts_in_if.sink    in_chan,
  input  logic      q_full,
  output logic      push,
  output rec_t      push_rec
);

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_IDENT   = 4'd1;
  localparam logic [3:0] M_OTHER   = 4'd2;
  localparam logic [3:0] M_STR     = 4'd3;
  localparam logic [3:0] M_STR_ESC = 4'd4;
  localparam logic [3:0] M_CHR     = 4'd5;
  localparam logic [3:0] M_CHR_ESC = 4'd6;
  localparam logic [3:0] M_LINE1   = 4'd7;
  localparam logic [3:0] M_LINE    = 4'd8;
  localparam logic [3:0] M_BLK1    = 4'd9;
  localparam logic [3:0] M_BLK     = 4'd10;
  localparam logic [3:0] M_BLK2    = 4'd11;

  function automatic logic [KIND_WIDTH-1:0] open_kind(input logic [3:0] m);
    logic [KIND_WIDTH-1:0] k;
    case (m)
      M_IDENT: k = K_IDENT;
      M_OTHER: k = K_OTHER;
      M_STR, M_STR_ESC: k = K_STRING;
      M_CHR, M_CHR_ESC: k = K_CHAR;
      M_LINE1, M_LINE: k = K_LINE;
      default: k = K_BLOCK;
    endcase
    return k;
  endfunction

  logic [3:0]              mode_r, mode_nxt, p_mode;
  logic [BYTE_WIDTH-1:0]   held_r, held_nxt;
  logic                    held_vld_r, held_vld_nxt;
  logic                    dig_r, dig_nxt;
  logic [OFFSET_WIDTH-1:0] off_r, off_nxt, p_off;
  logic [LINE_WIDTH-1:0]   line_r, line_nxt, p_line;
  logic [COLUMN_WIDTH-1:0] col_r, col_nxt, p_col;
  logic [OFFSET_WIDTH-1:0] tso_r, tso_nxt, p_tso;
  logic [LINE_WIDTH-1:0]   tsl_r, tsl_nxt, p_tsl;
  logic [COLUMN_WIDTH-1:0] tsc_r, tsc_nxt, p_tsc;
  logic [OFFSET_WIDTH-1:0] len_r, len_nxt, p_len;

  logic                    acc, end_item, nv, start;
  logic [BYTE_WIDTH-1:0]   c, n;
  logic                    a_vld, b_vld;
  tok_t                    a_tok, b_tok, c_tok, e_tok;
  logic [SLOT_WIDTH-1:0]   slot;
  rec_t                    rec;

  assign in_chan.ready = !q_full;
  assign acc           = in_chan.valid && in_chan.ready;
  assign end_item      = (in_chan.kind == IN_END);
  assign nv            = !end_item;
  assign n             = nv ? in_chan.source_byte : '0;
  assign c             = held_r;

  // scanner step on the held byte
  always_comb begin
    p_mode = mode_r;
    p_off  = off_r;
    p_line = line_r;
    p_col  = col_r;
    p_tso  = tso_r;
    p_tsl  = tsl_r;
    p_tsc  = tsc_r;
    p_len  = len_r;
    start  = 1'b0;
    a_vld  = 1'b0;
    b_vld  = 1'b0;
    a_tok  = '{kind: K_OTHER, start_offset: tso_r, token_length: len_r,
               start_line: tsl_r, start_column: tsc_r};
    b_tok  = '{kind: K_OPEN, start_offset: off_r, token_length: OFFSET_WIDTH'(1),
               start_line: line_r, start_column: col_r};
    if (held_vld_r) begin
      case (mode_r)
        M_IDENT: begin
          if (!is_ident_char(c)) begin
            a_vld = 1'b1; a_tok.kind = K_IDENT; start = 1'b1;
          end
        end
        M_OTHER: begin
          if (starts_token(c, dig_r, nv, n)) begin
            a_vld = 1'b1; a_tok.kind = K_OTHER; start = 1'b1;
          end
        end
        M_STR: begin
          if (c == CH_DQUOTE) begin
            a_vld = 1'b1; a_tok.kind = K_STRING; a_tok.token_length = sat_off(len_r);
            p_mode = M_IDLE;
          end else if (c == CH_BSLASH) begin
            p_mode = M_STR_ESC;
          end
        end
        M_CHR: begin
          if (c == CH_SQUOTE) begin
            a_vld = 1'b1; a_tok.kind = K_CHAR; a_tok.token_length = sat_off(len_r);
            p_mode = M_IDLE;
          end else if (c == CH_BSLASH) begin
            p_mode = M_CHR_ESC;
          end
        end
        M_STR_ESC: p_mode = M_STR;
        M_CHR_ESC: p_mode = M_CHR;
        M_LINE1:   p_mode = M_LINE;
        M_LINE: begin
          if (c == CH_NL) begin
            a_vld = 1'b1; a_tok.kind = K_LINE; start = 1'b1;
          end
        end
        M_BLK1: p_mode = M_BLK;
        M_BLK: begin
          if ((c == CH_STAR) && nv && (n == CH_SLASH)) p_mode = M_BLK2;
        end
        M_BLK2: begin
          a_vld = 1'b1; a_tok.kind = K_BLOCK; a_tok.token_length = sat_off(len_r);
          p_mode = M_IDLE;
        end
        default: start = 1'b1;
      endcase

      p_off = sat_off(off_r);
      if (c == CH_NL) begin
        p_line = sat_line(line_r);
        p_col  = COLUMN_WIDTH'(1);
      end else begin
        p_col  = sat_col(col_r);
      end

      if (start) begin
        p_tso = off_r;
        p_tsl = line_r;
        p_tsc = col_r;
        p_len = OFFSET_WIDTH'(1);
        if (is_ident_start(c)) begin
          p_mode = M_IDENT;
        end else if (c == CH_DQUOTE) begin
          p_mode = M_STR;
        end else if ((c == CH_SQUOTE) && !dig_r) begin
          p_mode = M_CHR;
        end else if ((c == CH_SLASH) && nv && (n == CH_SLASH)) begin
          p_mode = M_LINE1;
        end else if ((c == CH_SLASH) && nv && (n == CH_STAR)) begin
          p_mode = M_BLK1;
        end else if (c == CH_LBRACE) begin
          b_vld = 1'b1; b_tok.kind = K_OPEN; p_mode = M_IDLE;
        end else if (c == CH_RBRACE) begin
          b_vld = 1'b1; b_tok.kind = K_CLOSE; p_mode = M_IDLE;
        end else begin
          p_mode = M_OTHER;
        end
      end else begin
        p_len = sat_off(len_r);
      end
    end
  end

  // pack the tokens of this request in order
  always_comb begin
    c_tok = '{kind: open_kind(p_mode), start_offset: p_tso, token_length: p_len,
              start_line: p_tsl, start_column: p_tsc};
    e_tok = '{kind: K_EOF, start_offset: p_off, token_length: '0,
              start_line: p_line, start_column: p_col};
    rec   = '0;
    slot  = '0;
    if (a_vld) begin
      rec.tok[slot] = a_tok;
      slot = slot + 1'b1;
    end
    if (b_vld && (slot < SLOT_WIDTH'(MAX_TOKENS))) begin
      rec.tok[slot] = b_tok;
      slot = slot + 1'b1;
    end
    if (end_item) begin
      if ((p_mode != M_IDLE) && (slot < SLOT_WIDTH'(MAX_TOKENS))) begin
        rec.tok[slot] = c_tok;
        slot = slot + 1'b1;
      end
      if (slot < SLOT_WIDTH'(MAX_TOKENS)) begin
        rec.tok[slot] = e_tok;
        slot = slot + 1'b1;
      end
    end
    rec.count = slot;
  end

  assign push     = acc && (rec.count != '0);
  assign push_rec = rec;

  always_comb begin
    if (end_item) begin
      mode_nxt     = M_IDLE;
      held_nxt     = '0;
      held_vld_nxt = 1'b0;
      dig_nxt      = 1'b0;
      off_nxt      = '0;
      line_nxt     = LINE_WIDTH'(1);
      col_nxt      = COLUMN_WIDTH'(1);
      tso_nxt      = '0;
      tsl_nxt      = LINE_WIDTH'(1);
      tsc_nxt      = COLUMN_WIDTH'(1);
      len_nxt      = '0;
    end else begin
      mode_nxt     = p_mode;
      held_nxt     = in_chan.source_byte;
      held_vld_nxt = 1'b1;
      dig_nxt      = held_vld_r && is_digit(held_r);
      off_nxt      = p_off;
      line_nxt     = p_line;
      col_nxt      = p_col;
      tso_nxt      = p_tso;
      tsl_nxt      = p_tsl;
      tsc_nxt      = p_tsc;
      len_nxt      = p_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_IDLE;
      held_r     <= '0;
      held_vld_r <= 1'b0;
      dig_r      <= 1'b0;
      off_r      <= '0;
      line_r     <= LINE_WIDTH'(1);
      col_r      <= COLUMN_WIDTH'(1);
      tso_r      <= '0;
      tsl_r      <= LINE_WIDTH'(1);
      tsc_r      <= COLUMN_WIDTH'(1);
      len_r      <= '0;
    end else if (acc) begin
      mode_r     <= mode_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
      dig_r      <= dig_nxt;
      off_r      <= off_nxt;
      line_r     <= line_nxt;
      col_r      <= col_nxt;
      tso_r      <= tso_nxt;
      tsl_r      <= tsl_nxt;
      tsc_r      <= tsc_nxt;
      len_r      <= len_nxt;
    end
  end

endmodule

[hw/rtl/sts_queue.sv]
// short record queue between front and back ends
module sts_queue import sts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_rec,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output rec_t pop_rec
);

  rec_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == QUEUE_CW'(QUEUE_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign pop_rec  = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/sts_back.sv]
// back end: walks each record and drives one token request per cycle while out_chan.ready is high
module sts_back import sts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_nonempty,
  input  rec_t      q_rec,
  output logic      pop,
  sts_out_if.source out_chan
);

  rec_t                  rec_r;
  logic                  have_r;
  logic [SLOT_WIDTH-1:0] idx_r;
  logic                  last, take;
  tok_t                  cur;

  assign last = (idx_r == rec_r.count - 1'b1);
  assign take = !have_r || (out_chan.ready && last);
  assign pop  = q_nonempty && take;
  assign cur  = rec_r.tok[idx_r];

  assign out_chan.valid        = have_r;
  assign out_chan.token_kind   = cur.kind;
  assign out_chan.start_offset = cur.start_offset;
  assign out_chan.token_length = cur.token_length;
  assign out_chan.start_line   = cur.start_line;
  assign out_chan.start_column = cur.start_column;
  assign out_chan.last_in_run  = last;

  always_ff @(posedge clk) begin
    if (pop) rec_r <= q_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      idx_r  <= '0;
    end else if (take) begin
      have_r <= q_nonempty;
      idx_r  <= '0;
    end else if (out_chan.ready) begin
      idx_r  <= idx_r + 1'b1;
    end
  end

endmodule

[hw/rtl/source_code_token_splitter.sv]
// top level of the coarse source token splitter
// throughput: one byte request per cycle while the queue is not full; a request that
//   closes two or three tokens sends them in turn; a four-record queue absorbs bursts
// path: tokens are queued when the next (lookahead) request is taken, then go via rec_r
// reset: synchronous active-low rst_n empties the queue and output and returns the
//   scanner to idle at offset 0, line 1, column 1; no clearing pass
module source_code_token_splitter import sts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sts_in_if.sink    in_chan,
  sts_out_if.source out_chan
);

  logic q_full, q_push, q_pop, q_nonempty;
  rec_t q_push_rec, q_pop_rec;

  sts_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_full   (q_full),
    .push     (q_push),
    .push_rec (q_push_rec)
  );

  sts_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .pop_rec  (q_pop_rec)
  );

  sts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_rec      (q_pop_rec),
    .pop        (q_pop),
    .out_chan   (out_chan)
  );

endmodule

[hw/rtl/sts_checker.sv]
// port-level assertions for the token splitter, bound to the top level
module sts_checker import sts_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [KIND_WIDTH-1:0]   out_token_kind,
  input logic [OFFSET_WIDTH-1:0] out_token_length,
  input logic [LINE_WIDTH-1:0]   out_start_line,
  input logic [COLUMN_WIDTH-1:0] out_start_column,
  input logic                    out_last_in_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind) &&
    $stable(out_token_length))
    else $error("token request dropped or changed while stalled");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == K_EOF) |-> out_last_in_run && (out_token_length == '0))
    else $error("end-of-file token not last or not empty");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind != K_EOF) |-> (out_token_length != '0))
    else $error("token with zero length");

  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_start_line != '0) && (out_start_column != '0))
    else $error("line or column is zero");

endmodule

bind source_code_token_splitter sts_checker u_sts_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_token_kind   (out_chan.token_kind),
  .out_token_length (out_chan.token_length),
  .out_start_line   (out_chan.start_line),
  .out_start_column (out_chan.start_column),
  .out_last_in_run  (out_chan.last_in_run)
);

[dv/tb.sv]
// testbench for the token splitter: a directed table, then random source text, checked by a lexer
`timescale 1ns / 1ps

module tb;
  import sts_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 12;
  localparam int RAND_ITEMS   = 140;
  localparam int QUIET_FROM   = 60;
  localparam int QUIET_TO     = 100;
  localparam int HOLD_AT      = 35;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DIR_ROWS     = 27;

  typedef enum logic [3:0] {
    SC_IDLE, SC_IDENT, SC_OTHER, SC_STR, SC_STR_ESC, SC_CHR, SC_CHR_ESC,
    SC_LINE1, SC_LINE, SC_BLK1, SC_BLK, SC_BLK2
  } scan_t;

  typedef struct packed {
    logic [KIND_WIDTH-1:0]   kind;
    logic [OFFSET_WIDTH-1:0] start_offset;
    logic [OFFSET_WIDTH-1:0] token_length;
    logic [LINE_WIDTH-1:0]   start_line;
    logic [COLUMN_WIDTH-1:0] start_column;
    logic                    last;
  } exp_tok_t;

  typedef struct packed {
    logic                  kind;
    logic [BYTE_WIDTH-1:0] ch;
    logic                  typed;
    exp_tok_t              tok;
  } dir_row_t;

  typedef struct packed {
    logic                  kind;
    logic [BYTE_WIDTH-1:0] ch;
    logic                  quiet;
  } stim_t;

  localparam exp_tok_t NO_TOK = '0;
  localparam exp_tok_t EOF_AT_RESET = '{kind: K_EOF, start_offset: '0, token_length: '0,
                                        start_line: LINE_WIDTH'(1),
                                        start_column: COLUMN_WIDTH'(1), last: 1'b1};

  logic clk = 1'b0;
  logic rst_n;

  sts_in_if  in_if ();
  sts_out_if out_if ();

  source_code_token_splitter i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{IN_END,  8'h5A,     1'b1, EOF_AT_RESET},
    '{IN_END,  8'hA5,     1'b1, EOF_AT_RESET},
    '{IN_BYTE, CH_USCORE, 1'b0, NO_TOK},
    '{IN_BYTE, CH_D9,     1'b0, NO_TOK},
    '{IN_BYTE, CH_DQUOTE, 1'b0, NO_TOK},
    '{IN_BYTE, CH_BSLASH, 1'b0, NO_TOK},
    '{IN_BYTE, CH_DQUOTE, 1'b0, NO_TOK},
    '{IN_BYTE, CH_DQUOTE, 1'b0, NO_TOK},
    '{IN_BYTE, 8'h31,     1'b0, NO_TOK},
    '{IN_BYTE, CH_SQUOTE, 1'b0, NO_TOK},
    '{IN_BYTE, CH_SQUOTE, 1'b0, NO_TOK},
    '{IN_BYTE, CH_UA,     1'b0, NO_TOK},
    '{IN_BYTE, CH_SQUOTE, 1'b0, NO_TOK},
    '{IN_BYTE, CH_SLASH,  1'b0, NO_TOK},
    '{IN_BYTE, CH_SLASH,  1'b0, NO_TOK},
    '{IN_BYTE, CH_NL,     1'b0, NO_TOK},
    '{IN_BYTE, CH_SLASH,  1'b0, NO_TOK},
    '{IN_BYTE, CH_STAR,   1'b0, NO_TOK},
    '{IN_BYTE, CH_SLASH,  1'b0, NO_TOK},
    '{IN_BYTE, CH_STAR,   1'b0, NO_TOK},
    '{IN_BYTE, CH_SLASH,  1'b0, NO_TOK},
    '{IN_BYTE, CH_LBRACE, 1'b0, NO_TOK},
    '{IN_BYTE, CH_RBRACE, 1'b0, NO_TOK},
    '{IN_BYTE, 8'hFF,     1'b0, NO_TOK},
    '{IN_BYTE, 8'h00,     1'b0, NO_TOK},
    '{IN_BYTE, CH_DQUOTE, 1'b0, NO_TOK},
    '{IN_END,  8'hC3,     1'b0, NO_TOK}
  };

  exp_tok_t token_q [$];
  stim_t    stim_q [$];
  int       errors = 0;
  int       rx_count = 0;
  int       cycle_cnt = 0;
  bit       quiet = 1'b0;
  bit       fill_quiet = 1'b0;

  // lexer state
  logic [BYTE_WIDTH-1:0]   held_ch;
  logic                    held_ok;
  logic                    held_after_digit;
  scan_t                   scan;
  logic [OFFSET_WIDTH-1:0] cur_off, tok_off, tok_len;
  logic [LINE_WIDTH-1:0]   cur_line, tok_line;
  logic [COLUMN_WIDTH-1:0] cur_col, tok_col;

  function automatic bit ident_head(input logic [BYTE_WIDTH-1:0] c);
    return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ)) ||
           (c == CH_USCORE);
  endfunction

  task automatic lex_clear();
    held_ch = '0;
    held_ok = 1'b0;
    held_after_digit = 1'b0;
    scan = SC_IDLE;
    cur_off = '0;
    cur_line = LINE_WIDTH'(1);
    cur_col = COLUMN_WIDTH'(1);
    tok_off = '0;
    tok_line = LINE_WIDTH'(1);
    tok_col = COLUMN_WIDTH'(1);
    tok_len = '0;
  endtask

  task automatic advance(input logic [BYTE_WIDTH-1:0] c);
    if (c == CH_NL) begin
      if (cur_line != '1) cur_line = cur_line + 1'b1;
      cur_col = COLUMN_WIDTH'(1);
    end else if (cur_col != '1) begin
      cur_col = cur_col + 1'b1;
    end
    if (cur_off != '1) cur_off = cur_off + 1'b1;
    if (tok_len != '1) tok_len = tok_len + 1'b1;
  endtask

  task automatic push_token(input logic [KIND_WIDTH-1:0] k, input bit at_eof);
    exp_tok_t t;
    t.kind = k;
    t.start_offset = at_eof ? cur_off : tok_off;
    t.token_length = at_eof ? '0 : tok_len;
    t.start_line = at_eof ? cur_line : tok_line;
    t.start_column = at_eof ? cur_col : tok_col;
    t.last = 1'b0;
    token_q.push_back(t);
  endtask

  task automatic scan_char(input logic [BYTE_WIDTH-1:0] c, input bit dig, input bit nv,
                           input logic [BYTE_WIDTH-1:0] n);
    bit restart;
    restart = 1'b0;
    case (scan)
      SC_IDENT: begin
        if (ident_head(c) || ((c >= CH_D0) && (c <= CH_D9))) advance(c);
        else begin
          push_token(K_IDENT, 1'b0);
          restart = 1'b1;
        end
      end
      SC_OTHER: begin
        if (ident_head(c) || (c == CH_DQUOTE) || (c == CH_LBRACE) || (c == CH_RBRACE) ||
            ((c == CH_SQUOTE) && !dig) ||
            ((c == CH_SLASH) && nv && ((n == CH_SLASH) || (n == CH_STAR)))) begin
          push_token(K_OTHER, 1'b0);
          restart = 1'b1;
        end else begin
          advance(c);
        end
      end
      SC_STR, SC_CHR: begin
        advance(c);
        if (c == ((scan == SC_STR) ? CH_DQUOTE : CH_SQUOTE)) begin
          push_token((scan == SC_STR) ? K_STRING : K_CHAR, 1'b0);
          scan = SC_IDLE;
        end else if (c == CH_BSLASH) begin
          scan = (scan == SC_STR) ? SC_STR_ESC : SC_CHR_ESC;
        end
      end
      SC_STR_ESC: begin
        advance(c);
        scan = SC_STR;
      end
      SC_CHR_ESC: begin
        advance(c);
        scan = SC_CHR;
      end
      SC_LINE1: begin
        advance(c);
        scan = SC_LINE;
      end
      SC_LINE: begin
        if (c != CH_NL) advance(c);
        else begin
          push_token(K_LINE, 1'b0);
          restart = 1'b1;
        end
      end
      SC_BLK1: begin
        advance(c);
        scan = SC_BLK;
      end
      SC_BLK: begin
        advance(c);
        if ((c == CH_STAR) && nv && (n == CH_SLASH)) scan = SC_BLK2;
      end
      SC_BLK2: begin
        advance(c);
        push_token(K_BLOCK, 1'b0);
        scan = SC_IDLE;
      end
      default: restart = 1'b1;
    endcase
    if (restart) begin
      tok_off = cur_off;
      tok_line = cur_line;
      tok_col = cur_col;
      tok_len = '0;
      advance(c);
      if (ident_head(c)) scan = SC_IDENT;
      else if (c == CH_DQUOTE) scan = SC_STR;
      else if ((c == CH_SQUOTE) && !dig) scan = SC_CHR;
      else if ((c == CH_SLASH) && nv && (n == CH_SLASH)) scan = SC_LINE1;
      else if ((c == CH_SLASH) && nv && (n == CH_STAR)) scan = SC_BLK1;
      else if (c == CH_LBRACE) begin
        push_token(K_OPEN, 1'b0);
        scan = SC_IDLE;
      end else if (c == CH_RBRACE) begin
        push_token(K_CLOSE, 1'b0);
        scan = SC_IDLE;
      end else begin
        scan = SC_OTHER;
      end
    end
  endtask

  task automatic lex_request(input logic k, input logic [BYTE_WIDTH-1:0] b);
    int n0;
    bit dig_next;
    logic [KIND_WIDTH-1:0] open_kind;
    n0 = token_q.size();
    if (k == IN_BYTE) begin
      dig_next = 1'b0;
      if (held_ok) begin
        scan_char(held_ch, held_after_digit, 1'b1, b);
        dig_next = (held_ch >= CH_D0) && (held_ch <= CH_D9);
      end
      held_ch = b;
      held_ok = 1'b1;
      held_after_digit = dig_next;
    end else begin
      if (held_ok) scan_char(held_ch, held_after_digit, 1'b0, '0);
      if (scan != SC_IDLE) begin
        case (scan)
          SC_IDENT:             open_kind = K_IDENT;
          SC_OTHER:             open_kind = K_OTHER;
          SC_STR, SC_STR_ESC:   open_kind = K_STRING;
          SC_CHR, SC_CHR_ESC:   open_kind = K_CHAR;
          SC_LINE1, SC_LINE:    open_kind = K_LINE;
          default:              open_kind = K_BLOCK;
        endcase
        push_token(open_kind, 1'b0);
      end
      push_token(K_EOF, 1'b1);
      lex_clear();
    end
    if (token_q.size() > n0) token_q[token_q.size() - 1].last = 1'b1;
  endtask

  task automatic send_request(input logic k, input logic [BYTE_WIDTH-1:0] b, input bit q,
                              input bit typed, input exp_tok_t tok);
    int gap;
    int n0;
    gap = q ? 0 : $urandom_range(0, 9);
    quiet = q;
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.kind <= k;
    in_if.source_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    n0 = token_q.size();
    lex_request(k, b);
    if (typed) begin
      while (token_q.size() > n0) void'(token_q.pop_back());
      token_q.push_back(tok);
    end
  endtask

  task automatic put(input logic k, input logic [BYTE_WIDTH-1:0] c);
    stim_q.push_back('{kind: k, ch: c, quiet: fill_quiet});
  endtask

  function automatic logic [BYTE_WIDTH-1:0] rand_byte();
    return BYTE_WIDTH'($urandom_range(0, 255));
  endfunction

  function automatic logic [BYTE_WIDTH-1:0] text_byte();
    return BYTE_WIDTH'($urandom_range(8'h20, 8'h7E));
  endfunction

  function automatic logic [BYTE_WIDTH-1:0] digit_byte();
    return CH_D0 + BYTE_WIDTH'($urandom_range(0, 9));
  endfunction

  function automatic logic [BYTE_WIDTH-1:0] ident_byte(input bit head);
    case ($urandom_range(0, head ? 2 : 3))
      0:       return CH_UA + BYTE_WIDTH'($urandom_range(0, 25));
      1:       return CH_LA + BYTE_WIDTH'($urandom_range(0, 25));
      2:       return CH_USCORE;
      default: return digit_byte();
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d tokens outstanding", $time, token_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    exp_tok_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      rx_count++;
      if (token_q.size() == 0) begin
        $display("%0t: unexpected token, expected none, actual kind %0d offset %0d",
                 $time, out_if.token_kind, out_if.start_offset);
        errors++;
      end else begin
        want = token_q.pop_front();
        check_field("token_kind", 32'(want.kind), 32'(out_if.token_kind));
        check_field("start_offset", 32'(want.start_offset), 32'(out_if.start_offset));
        check_field("token_length", 32'(want.token_length), 32'(out_if.token_length));
        check_field("start_line", 32'(want.start_line), 32'(out_if.start_line));
        check_field("start_column", 32'(want.start_column), 32'(out_if.start_column));
        check_field("last_in_run", 32'(want.last), 32'(out_if.last_in_run));
      end
    end
  end

  // token receiver with random stalls and one long hold-off
  initial begin
    int  stall;
    bit  held_off;
    held_off = 1'b0;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = quiet ? 0 : $urandom_range(0, 9);
      if (!held_off && rx_count >= HOLD_AT) begin
        held_off = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.kind <= IN_BYTE;
    in_if.source_byte <= '0;
    lex_clear();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_request(dir_tab[i].kind, dir_tab[i].ch, 1'b0, dir_tab[i].typed, dir_tab[i].tok);
    end

    // random source text built from token-shaped fragments
    while (stim_q.size() < RAND_ITEMS) begin
      fill_quiet = (stim_q.size() >= QUIET_FROM) && (stim_q.size() < QUIET_TO);
      case ($urandom_range(0, 11))
        0, 1, 2: begin
          put(IN_BYTE, ident_byte(1'b1));
          repeat ($urandom_range(0, 5)) put(IN_BYTE, ident_byte(1'b0));
        end
        3: begin
          put(IN_BYTE, CH_DQUOTE);
          repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 3) == 0) begin
              put(IN_BYTE, CH_BSLASH);
              put(IN_BYTE, rand_byte());
            end else begin
              put(IN_BYTE, text_byte());
            end
          end
          if ($urandom_range(0, 7) != 0) put(IN_BYTE, CH_DQUOTE);
        end
        4: begin
          put(IN_BYTE, CH_SQUOTE);
          if ($urandom_range(0, 2) == 0) begin
            put(IN_BYTE, CH_BSLASH);
            put(IN_BYTE, rand_byte());
          end else begin
            put(IN_BYTE, text_byte());
          end
          put(IN_BYTE, CH_SQUOTE);
        end
        5: begin
          repeat ($urandom_range(1, 3)) put(IN_BYTE, digit_byte());
          put(IN_BYTE, CH_SQUOTE);
          repeat ($urandom_range(1, 3)) put(IN_BYTE, digit_byte());
        end
        6: begin
          put(IN_BYTE, CH_SLASH);
          put(IN_BYTE, CH_SLASH);
          repeat ($urandom_range(0, 5)) put(IN_BYTE, text_byte());
          put(IN_BYTE, CH_NL);
        end
        7: begin
          put(IN_BYTE, CH_SLASH);
          put(IN_BYTE, CH_STAR);
          repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 2))
              0:       put(IN_BYTE, CH_STAR);
              1:       put(IN_BYTE, CH_SLASH);
              default: put(IN_BYTE, text_byte());
            endcase
          end
          put(IN_BYTE, CH_STAR);
          put(IN_BYTE, CH_SLASH);
        end
        8: put(IN_BYTE, $urandom_range(0, 1) ? CH_LBRACE : CH_RBRACE);
        9: begin
          case ($urandom_range(0, 2))
            0:       put(IN_BYTE, 8'h20);
            1:       put(IN_BYTE, CH_NL);
            default: put(IN_BYTE, 8'h09);
          endcase
        end
        10: repeat ($urandom_range(1, 3)) put(IN_BYTE, rand_byte());
        default: begin
          put(IN_BYTE, CH_SLASH);
          put(IN_BYTE, rand_byte());
        end
      endcase
      if ($urandom_range(0, 11) == 0) put(IN_END, rand_byte());
    end
    put(IN_END, rand_byte());

    foreach (stim_q[i]) begin
      send_request(stim_q[i].kind, stim_q[i].ch, stim_q[i].quiet, 1'b0, NO_TOK);
    end
    @(negedge clk);
    in_if.valid <= 1'b0;

    while (token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && token_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
